// ----- sv/hbr_pkg.sv -----
// ----------------------------------------------------------------------------
// hbr_pkg: shared types, constants and microprogram for the HSV breathing ramp
// Holds the beat payload structs, register map, channel and opcode codes,
// and the control store of the step sequencer.
// ----------------------------------------------------------------------------
package hbr_pkg;

  // Beat payloads
  typedef struct packed {
    logic       opcode;
    logic [1:0] channel;
    logic [7:0] level_in;
  } tick_t;

  typedef struct packed {
    logic [7:0] level_out;
    logic       done_res;
  } res_t;

  // Opcodes and channels
  localparam logic       OP_PLAIN    = 1'b0;
  localparam logic       OP_HARMONIC = 1'b1;
  localparam logic [1:0] CH_HUE      = 2'd0;
  localparam logic [1:0] CH_SAT      = 2'd1;
  localparam logic [1:0] CH_VAL      = 2'd2;

  // Register map (word index on the APB port)
  localparam logic [2:0] REG_ENABLE     = 3'd0;
  localparam logic [2:0] REG_HUE_PEAK   = 3'd1;
  localparam logic [2:0] REG_SAT_FLOOR  = 3'd2;
  localparam logic [2:0] REG_VALUE_PEAK = 3'd3;
  localparam logic [2:0] REG_HUE_STEP   = 3'd4;
  localparam logic [2:0] REG_SAT_STEP   = 3'd5;
  localparam logic [2:0] REG_VALUE_STEP = 3'd6;

  localparam int          PADDR_W = 5;
  localparam int          PDATA_W = 32;

  // Channel limits
  localparam logic [7:0] SAT_MAX      = 8'd100;
  localparam logic [7:0] SAT_MIN_LOW  = 8'd80;
  localparam logic [7:0] SAT_MIN_HIGH = 8'd90;
  localparam logic [2:0] SAT_FLOOR_SW = 3'd1;
  localparam logic [2:0] BREATHS      = 3'd5;

  // Reciprocal of 10 and 5: x/10 = (x*205)>>11, x/5 = (x*205)>>10 for x < 256
  localparam logic [7:0] RECIP_MUL    = 8'd205;

  // Datapath actions
  localparam logic [3:0] A_NONE     = 4'd0;
  localparam logic [3:0] A_LOAD     = 4'd1;
  localparam logic [3:0] A_LIMITS   = 4'd2;
  localparam logic [3:0] A_SCALE    = 4'd3;
  localparam logic [3:0] A_PEAK     = 4'd4;
  localparam logic [3:0] A_DIV_INIT = 4'd5;
  localparam logic [3:0] A_DIV_STEP = 4'd6;
  localparam logic [3:0] A_DIV_END  = 4'd7;
  localparam logic [3:0] A_RAMP     = 4'd8;
  localparam logic [3:0] A_BREATH   = 4'd9;
  localparam logic [3:0] A_FINISH   = 4'd10;

  // Jump conditions
  localparam logic [2:0] C_NEVER      = 3'd0;
  localparam logic [2:0] C_ALWAYS     = 3'd1;
  localparam logic [2:0] C_NO_BEAT    = 3'd2;
  localparam logic [2:0] C_DISABLED   = 3'd3;
  localparam logic [2:0] C_PLAIN      = 3'd4;
  localparam logic [2:0] C_TENTH_ZERO = 3'd5;
  localparam logic [2:0] C_DIV_MORE   = 3'd6;
  localparam logic [2:0] C_OUT_BUSY   = 3'd7;

  // Program steps
  localparam logic [3:0] S_WAIT     = 4'd0;
  localparam logic [3:0] S_LIMITS   = 4'd1;
  localparam logic [3:0] S_SCALE    = 4'd2;
  localparam logic [3:0] S_PEAK     = 4'd3;
  localparam logic [3:0] S_DIV_INIT = 4'd4;
  localparam logic [3:0] S_DIV_STEP = 4'd5;
  localparam logic [3:0] S_DIV_END  = 4'd6;
  localparam logic [3:0] S_RAMP     = 4'd7;
  localparam logic [3:0] S_BREATH   = 4'd8;
  localparam logic [3:0] S_FINISH   = 4'd9;
  localparam logic [3:0] S_RETURN   = 4'd10;

  typedef struct packed {
    logic [3:0] act;
    logic [2:0] cond;
    logic [3:0] target;
  } ctrl_word_t;

  // Control store: one word per step, jump to target when cond holds
  function automatic ctrl_word_t ucode(input logic [3:0] pc);
    ctrl_word_t w;
    unique case (pc)
      S_WAIT:     w = '{A_LOAD,     C_NO_BEAT,    S_WAIT};
      S_LIMITS:   w = '{A_LIMITS,   C_DISABLED,   S_FINISH};
      S_SCALE:    w = '{A_SCALE,    C_PLAIN,      S_RAMP};
      S_PEAK:     w = '{A_PEAK,     C_NEVER,      S_WAIT};
      S_DIV_INIT: w = '{A_DIV_INIT, C_TENTH_ZERO, S_RAMP};
      S_DIV_STEP: w = '{A_DIV_STEP, C_DIV_MORE,   S_DIV_STEP};
      S_DIV_END:  w = '{A_DIV_END,  C_NEVER,      S_WAIT};
      S_RAMP:     w = '{A_RAMP,     C_PLAIN,      S_FINISH};
      S_BREATH:   w = '{A_BREATH,   C_NEVER,      S_WAIT};
      S_FINISH:   w = '{A_FINISH,   C_OUT_BUSY,   S_FINISH};
      S_RETURN:   w = '{A_NONE,     C_ALWAYS,     S_WAIT};
      default:    w = '{A_NONE,     C_ALWAYS,     S_WAIT};
    endcase
    return w;
  endfunction

endpackage

// ----- sv/hsv_breathing_ramp_top.sv -----
// ----------------------------------------------------------------------------
// hsv_breathing_ramp_top: one breathing-ramp tick for one HSV channel
// A microcoded sequencer steps a small datapath through limit lookup, peak
// decay, a bit-serial step divider and the up/down ramp of the level.
// ----------------------------------------------------------------------------
//  channel   | signals                                  | role
//  ----------+------------------------------------------+--------------------
//  tick      | tick_valid, tick_ready, tick (tick_t)    | level beat in
//  res       | res_valid, res_ready, res (res_t)        | new level beat out
//  apb       | psel penable pwrite paddr pwdata prdata  | register access
//
//  A disabled tick goes from limit lookup to the finish step, a plain
//  tick also runs the scale and ramp steps, and a harmonic tick adds the peak
//  decay, the 8-step restoring divider and the breath step (no divider when
//  the channel maximum is below 10). The sequencer accepts the next tick after
//  its return step. Reset (rst, synchronous) restores register defaults and
//  all ramp state. A stalled result holds the sequencer in its finish step;
//  once that result is taken the new one loads and the return step follows.
// ----------------------------------------------------------------------------
module hsv_breathing_ramp_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            tick_valid,
  output logic                            tick_ready,
  input  hbr_pkg::tick_t                  tick,
  output logic                            res_valid,
  input  logic                            res_ready,
  output hbr_pkg::res_t                   res,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [hbr_pkg::PADDR_W-1:0]     paddr,
  input  logic [hbr_pkg::PDATA_W-1:0]     pwdata,
  output logic [hbr_pkg::PDATA_W-1:0]     prdata,
  output logic                            pready
);

  // Configuration registers
  logic       enable;
  logic [6:0] hue_peak_half;
  logic [2:0] sat_floor_level;
  logic [6:0] value_peak;
  logic [6:0] hue_step;
  logic [6:0] sat_step;
  logic [6:0] value_step;

  // Ramp state
  logic       hue_falling;
  logic       sat_falling;
  logic       val_falling;
  logic [7:0] val_previous;
  logic [2:0] breath_count;

  // Sequencer
  logic [3:0]          pc;
  logic [3:0]          pc_next;
  hbr_pkg::ctrl_word_t cw;
  logic                cond_hit;
  logic                out_busy;

  // Datapath registers
  logic       op;
  logic [1:0] chan;
  logic [7:0] lvl;
  logic       done;
  logic [7:0] hi;
  logic [7:0] lo;
  logic [7:0] step;
  logic [4:0] tenth;
  logic [5:0] fifth;
  logic [7:0] peak;
  logic [7:0] rem;
  logic [7:0] quo;
  logic [2:0] div_cnt;

  // Combinational datapath
  logic       cfg_wr;
  logic [1:0] chan_in;
  logic [15:0] prod_hi;
  logic [8:0]  cut;
  logic [8:0]  trial;
  logic        dir_cur;
  logic [8:0]  sum;
  logic [7:0]  up_sat;
  logic [7:0]  up_lvl;
  logic [7:0]  dn_raw;
  logic [7:0]  dn_lvl;
  logic [7:0]  ramp_lvl;
  logic        ramp_dir;
  logic        ramp_fin;
  logic [2:0]  breath_inc;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      enable          <= 1'b0;
      hue_peak_half   <= 7'd50;
      sat_floor_level <= 3'd0;
      value_peak      <= 7'd100;
      hue_step        <= 7'd1;
      sat_step        <= 7'd1;
      value_step      <= 7'd1;
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        hbr_pkg::REG_ENABLE:     enable          <= pwdata[0];
        hbr_pkg::REG_HUE_PEAK:   hue_peak_half   <= pwdata[6:0];
        hbr_pkg::REG_SAT_FLOOR:  sat_floor_level <= pwdata[2:0];
        hbr_pkg::REG_VALUE_PEAK: value_peak      <= pwdata[6:0];
        hbr_pkg::REG_HUE_STEP:   hue_step        <= pwdata[6:0];
        hbr_pkg::REG_SAT_STEP:   sat_step        <= pwdata[6:0];
        hbr_pkg::REG_VALUE_STEP: value_step      <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  // Read back configuration registers
  always_comb begin
    prdata = '0;
    unique case (paddr[4:2])
      hbr_pkg::REG_ENABLE:     prdata[0]   = enable;
      hbr_pkg::REG_HUE_PEAK:   prdata[6:0] = hue_peak_half;
      hbr_pkg::REG_SAT_FLOOR:  prdata[2:0] = sat_floor_level;
      hbr_pkg::REG_VALUE_PEAK: prdata[6:0] = value_peak;
      hbr_pkg::REG_HUE_STEP:   prdata[6:0] = hue_step;
      hbr_pkg::REG_SAT_STEP:   prdata[6:0] = sat_step;
      hbr_pkg::REG_VALUE_STEP: prdata[6:0] = value_step;
      default:                 prdata      = '0;
    endcase
  end

  // Fetch the control word and resolve the jump
  assign cw         = hbr_pkg::ucode(pc);
  assign tick_ready = (pc == hbr_pkg::S_WAIT);
  assign out_busy   = res_valid && !res_ready;

  always_comb begin
    case (cw.cond)
      hbr_pkg::C_ALWAYS:     cond_hit = 1'b1;
      hbr_pkg::C_NO_BEAT:    cond_hit = !tick_valid;
      hbr_pkg::C_DISABLED:   cond_hit = !enable;
      hbr_pkg::C_PLAIN:      cond_hit = (op == hbr_pkg::OP_PLAIN);
      hbr_pkg::C_TENTH_ZERO: cond_hit = (tenth == 5'd0);
      hbr_pkg::C_DIV_MORE:   cond_hit = (div_cnt != 3'd7);
      hbr_pkg::C_OUT_BUSY:   cond_hit = out_busy;
      default:               cond_hit = 1'b0;
    endcase
    pc_next = cond_hit ? cw.target : pc + 4'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= hbr_pkg::S_WAIT;
    end else begin
      pc <= pc_next;
    end
  end

  // Fold the unused channel code onto the value channel
  assign chan_in = (tick.channel > hbr_pkg::CH_VAL) ? hbr_pkg::CH_VAL : tick.channel;

  // Reciprocal scaling, peak decay and one restoring divider bit
  assign prod_hi = {8'd0, hi} * {8'd0, hbr_pkg::RECIP_MUL};
  assign cut     = {6'd0, breath_count} * {3'd0, fifth};
  assign trial   = {rem, quo[7]};

  // Current direction, with the value channel following outside changes
  always_comb begin
    case (chan)
      hbr_pkg::CH_HUE: dir_cur = hue_falling;
      hbr_pkg::CH_SAT: dir_cur = sat_falling;
      default: begin
        if (lvl > val_previous) begin
          dir_cur = 1'b1;
        end else if (lvl < val_previous) begin
          dir_cur = 1'b0;
        end else begin
          dir_cur = val_falling;
        end
      end
    endcase
  end

  // Step the level up or down and pick the next direction
  always_comb begin
    sum    = {1'b0, lvl} + {1'b0, step};
    up_sat = sum[8] ? 8'hFF : sum[7:0];
    up_lvl = (step == 8'd0) ? lvl : ((up_sat >= hi) ? hi : up_sat);
    dn_raw = (lvl > step) ? lvl - step : lo;
    dn_lvl = (step == 8'd0) ? lvl : ((dn_raw < lo) ? lo : dn_raw);
    ramp_fin = 1'b0;
    if (!dir_cur) begin
      ramp_lvl = up_lvl;
      ramp_dir = (up_lvl == hi) || (step == 8'd0);
    end else begin
      ramp_lvl = dn_lvl;
      ramp_dir = 1'b1;
      if ((dn_lvl == lo) || (step == 8'd0)) begin
        ramp_dir = 1'b0;
        ramp_fin = 1'b1;
      end
    end
  end

  assign breath_inc = breath_count + 3'd1;

  // Datapath registers driven by the current action
  always_ff @(posedge clk) begin
    case (cw.act)
      hbr_pkg::A_LOAD: begin
        if (tick_valid) begin
          op   <= tick.opcode;
          chan <= chan_in;
          lvl  <= tick.level_in;
          done <= 1'b0;
        end
      end
      hbr_pkg::A_LIMITS: begin
        case (chan)
          hbr_pkg::CH_HUE: begin
            hi   <= {hue_peak_half, 1'b0};
            lo   <= 8'd0;
            step <= {1'b0, hue_step};
          end
          hbr_pkg::CH_SAT: begin
            hi   <= hbr_pkg::SAT_MAX;
            lo   <= (sat_floor_level > hbr_pkg::SAT_FLOOR_SW) ?
                    hbr_pkg::SAT_MIN_HIGH : hbr_pkg::SAT_MIN_LOW;
            step <= {1'b0, sat_step};
          end
          default: begin
            hi   <= {1'b0, value_peak};
            lo   <= 8'd0;
            step <= {1'b0, value_step};
          end
        endcase
      end
      hbr_pkg::A_SCALE: begin
        tenth <= prod_hi[15:11];
        fifth <= prod_hi[15:10];
      end
      hbr_pkg::A_PEAK: begin
        peak <= (cut > {1'b0, hi}) ? 8'd0 : hi - cut[7:0];
      end
      hbr_pkg::A_DIV_INIT: begin
        hi      <= peak;
        step    <= 8'd1;
        rem     <= 8'd0;
        quo     <= peak;
        div_cnt <= 3'd0;
      end
      hbr_pkg::A_DIV_STEP: begin
        div_cnt <= div_cnt + 3'd1;
        if (trial >= {4'd0, tenth}) begin
          rem <= 8'(trial - {4'd0, tenth});
          quo <= {quo[6:0], 1'b1};
        end else begin
          rem <= trial[7:0];
          quo <= {quo[6:0], 1'b0};
        end
      end
      hbr_pkg::A_DIV_END: begin
        step <= quo;
      end
      hbr_pkg::A_RAMP: begin
        lvl  <= ramp_lvl;
        done <= ramp_fin;
      end
      hbr_pkg::A_BREATH: begin
        done <= done && (breath_inc >= hbr_pkg::BREATHS);
      end
      default: ;
    endcase
  end

  // Ramp and breath state
  always_ff @(posedge clk) begin
    if (rst) begin
      hue_falling  <= 1'b0;
      sat_falling  <= 1'b0;
      val_falling  <= 1'b0;
      val_previous <= 8'd0;
      breath_count <= 3'd0;
    end else begin
      if (cw.act == hbr_pkg::A_RAMP) begin
        case (chan)
          hbr_pkg::CH_HUE: hue_falling <= ramp_dir;
          hbr_pkg::CH_SAT: sat_falling <= ramp_dir;
          default: begin
            val_falling  <= ramp_dir;
            val_previous <= ramp_lvl;
          end
        endcase
      end
      // Count a completed fall; wrap after the last breath
      if ((cw.act == hbr_pkg::A_BREATH) && done) begin
        breath_count <= (breath_inc >= hbr_pkg::BREATHS) ? 3'd0 : breath_inc;
      end
    end
  end

  // Output register: hold the result beat until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if ((cw.act == hbr_pkg::A_FINISH) && !out_busy) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((cw.act == hbr_pkg::A_FINISH) && !out_busy) begin
      res.level_out <= lvl;
      res.done_res  <= done;
    end
  end

endmodule

// ----- tb/sv/hsv_breathing_ramp_top_test.sv -----
// ----------------------------------------------------------------------------
// hsv_breathing_ramp_top_test: self-checking bench for the HSV breathing ramp
// Drives level beats through a random valid/ready handshake and programs the
// registers over APB between phases. A predictor tracks the ramp direction
// of every channel, the last value level and the harmonic breath count, and
// the monitor checks every result beat against the oldest predicted level.
// ----------------------------------------------------------------------------
module hsv_breathing_ramp_top_test;

  localparam int CYCLE_LIMIT = 600000;
  localparam int IDLE_PCT    = 38;
  localparam int HOLD_AT     = 700;
  localparam int HOLD_CYCLES = 300;

  typedef struct {
    hbr_pkg::tick_t t;
    bit             follow;   // take level_in from the last level given out on the lane
  } queued_tick_t;

  logic                        clk;
  logic                        rst = 1'b1;
  logic                        tick_valid = 1'b0;
  logic                        tick_ready;
  hbr_pkg::tick_t              tick = '0;
  logic                        res_valid;
  logic                        res_ready = 1'b0;
  hbr_pkg::res_t               res;
  logic                        psel = 1'b0;
  logic                        penable = 1'b0;
  logic                        pwrite = 1'b0;
  logic [hbr_pkg::PADDR_W-1:0] paddr = '0;
  logic [hbr_pkg::PDATA_W-1:0] pwdata = '0;
  logic [hbr_pkg::PDATA_W-1:0] prdata;
  logic                        pready;

  // Register shadow
  logic       cfg_en        = 1'b0;
  logic [6:0] cfg_hue_half  = 7'd50;
  logic [2:0] cfg_sat_floor = 3'd0;
  logic [6:0] cfg_val_peak  = 7'd100;
  logic [6:0] cfg_hue_step  = 7'd1;
  logic [6:0] cfg_sat_step  = 7'd1;
  logic [6:0] cfg_val_step  = 7'd1;

  // Ramp state
  logic       hue_dn   = 1'b0;
  logic       sat_dn   = 1'b0;
  logic       val_dn   = 1'b0;
  logic [7:0] val_last = 8'd0;
  logic [2:0] breaths  = 3'd0;
  logic [7:0] last_out [3] = '{8'd0, 8'd0, 8'd0};

  queued_tick_t  tick_backlog [$];
  hbr_pkg::res_t due_levels [$];
  int            mismatches = 0;
  int            res_count = 0;
  int            cycles = 0;
  int            stall_left = 0;
  bit            held_once = 1'b0;
  bit            steady = 1'b0;

  hsv_breathing_ramp_top dut (
    .clk        (clk),
    .rst        (rst),
    .tick_valid (tick_valid),
    .tick_ready (tick_ready),
    .tick       (tick),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Fold the unused channel code onto the value lane
  function automatic logic [1:0] lane(input logic [1:0] ch);
    return (ch == 2'd3) ? hbr_pkg::CH_VAL : ch;
  endfunction

  // Move one level a tick along its ramp; fin flags a completed fall
  function automatic void walk(input logic [1:0] ch, inout int unsigned v,
                               input int unsigned hi, input int unsigned lo,
                               input int unsigned stp, output bit fin);
    bit dn;
    fin = 1'b0;
    if (ch == hbr_pkg::CH_HUE) begin
      dn = hue_dn;
    end else if (ch == hbr_pkg::CH_SAT) begin
      dn = sat_dn;
    end else begin
      dn = val_dn;
      // follow outside changes of the value level
      if (v > val_last) dn = 1'b1;
      else if (v < val_last) dn = 1'b0;
    end

    if (!dn) begin
      if (stp > 0) begin
        v = v + stp;
        if (v > 255) v = 255;
        if (v >= hi) v = hi;
      end
      if (v == hi || stp == 0) dn = 1'b1;
    end else begin
      if (stp > 0) begin
        if (v > stp) v = v - stp;
        else v = lo;
        if (v < lo) v = lo;
      end
      if (v == lo || stp == 0) begin
        dn  = 1'b0;
        fin = 1'b1;
      end
    end

    v = v & 8'hFF;
    if (ch == hbr_pkg::CH_HUE) begin
      hue_dn = dn;
    end else if (ch == hbr_pkg::CH_SAT) begin
      sat_dn = dn;
    end else begin
      val_dn   = dn;
      val_last = v[7:0];
    end
  endfunction

  // Predict the result beat of one tick and advance the ramp state
  function automatic hbr_pkg::res_t next_level(input hbr_pkg::tick_t t);
    logic [1:0]    ch;
    int unsigned   hi, lo, stp, lvl, tenth, cut, peak;
    bit            fin;
    hbr_pkg::res_t r;
    ch  = lane(t.channel);
    lvl = t.level_in;
    r.done_res = 1'b0;
    if (cfg_en) begin
      case (ch)
        hbr_pkg::CH_HUE: begin
          lo  = 0;
          hi  = {cfg_hue_half, 1'b0};
          stp = cfg_hue_step;
        end
        hbr_pkg::CH_SAT: begin
          hi  = hbr_pkg::SAT_MAX;
          lo  = (cfg_sat_floor > hbr_pkg::SAT_FLOOR_SW) ?
                hbr_pkg::SAT_MIN_HIGH : hbr_pkg::SAT_MIN_LOW;
          stp = cfg_sat_step;
        end
        default: begin
          lo  = 0;
          hi  = cfg_val_peak;
          stp = cfg_val_step;
        end
      endcase

      if (t.opcode == hbr_pkg::OP_PLAIN) begin
        walk(ch, lvl, hi, lo, stp, fin);
        r.done_res = fin;
      end else begin
        // shrink the peak by a fifth per completed breath
        tenth = hi / 10;
        cut   = breaths * (hi / 5);
        peak  = (cut > hi) ? 0 : hi - cut;
        stp   = (tenth > 0) ? peak / tenth : 1;
        walk(ch, lvl, peak, lo, stp, fin);
        if (fin) begin
          breaths = breaths + 3'd1;
          if (breaths >= hbr_pkg::BREATHS) begin
            breaths    = 3'd0;
            r.done_res = 1'b1;
          end
        end
      end
    end
    r.level_out  = lvl[7:0];
    last_out[ch] = r.level_out;
    return r;
  endfunction

  // Tick driver: predict on accept, hold while stalled, offer next with gaps
  always @(posedge clk) begin : drive_ticks
    queued_tick_t   q;
    hbr_pkg::tick_t nt;
    if (rst) begin
      tick_valid <= 1'b0;
    end else begin
      if (tick_valid && tick_ready) begin
        due_levels.push_back(next_level(tick));
      end
      if (tick_valid && !tick_ready) begin
        // hold the beat
      end else if (tick_backlog.size() != 0 &&
                   (steady || $urandom_range(99) >= IDLE_PCT)) begin
        q  = tick_backlog.pop_front();
        nt = q.t;
        if (q.follow) nt.level_in = last_out[lane(nt.channel)];
        tick       <= nt;
        tick_valid <= 1'b1;
      end else begin
        tick_valid <= 1'b0;
      end
    end
  end

  // Result monitor: check each beat, stall at random, one long hold-off
  always @(posedge clk) begin : watch_results
    hbr_pkg::res_t want;
    if (rst) begin
      res_ready <= 1'b0;
    end else begin
      if (res_valid && res_ready) begin
        res_count++;
        if (due_levels.size() == 0) begin
          $display("%0t: result with none due: level_out %0d done_res %0d",
                   $time, res.level_out, res.done_res);
          mismatches++;
        end else begin
          want = due_levels.pop_front();
          if (res.level_out !== want.level_out) begin
            $display("%0t: level_out expected %0d actual %0d",
                     $time, want.level_out, res.level_out);
            mismatches++;
          end
          if (res.done_res !== want.done_res) begin
            $display("%0t: done_res expected %0d actual %0d",
                     $time, want.done_res, res.done_res);
            mismatches++;
          end
        end
      end

      if (!held_once && res_count == HOLD_AT) begin
        held_once  = 1'b1;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        stall_left--;
        res_ready <= 1'b0;
      end else begin
        res_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Update the register shadow after a completed write
  function automatic void shadow_reg(input logic [2:0] idx, input logic [31:0] val);
    case (idx)
      hbr_pkg::REG_ENABLE:     cfg_en        = val[0];
      hbr_pkg::REG_HUE_PEAK:   cfg_hue_half  = val[6:0];
      hbr_pkg::REG_SAT_FLOOR:  cfg_sat_floor = val[2:0];
      hbr_pkg::REG_VALUE_PEAK: cfg_val_peak  = val[6:0];
      hbr_pkg::REG_HUE_STEP:   cfg_hue_step  = val[6:0];
      hbr_pkg::REG_SAT_STEP:   cfg_sat_step  = val[6:0];
      hbr_pkg::REG_VALUE_STEP: cfg_val_step  = val[6:0];
      default: ;
    endcase
  endfunction

  // APB write: setup, access, complete on pready
  task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    shadow_reg(idx, val);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_all(input logic en, input logic [6:0] hh, input logic [2:0] sf,
                         input logic [6:0] vp, input logic [6:0] hs,
                         input logic [6:0] ss, input logic [6:0] vs);
    reg_write(hbr_pkg::REG_ENABLE, 32'(en));
    reg_write(hbr_pkg::REG_HUE_PEAK, 32'(hh));
    reg_write(hbr_pkg::REG_SAT_FLOOR, 32'(sf));
    reg_write(hbr_pkg::REG_VALUE_PEAK, 32'(vp));
    reg_write(hbr_pkg::REG_HUE_STEP, 32'(hs));
    reg_write(hbr_pkg::REG_SAT_STEP, 32'(ss));
    reg_write(hbr_pkg::REG_VALUE_STEP, 32'(vs));
  endtask

  // Wait until no beat is queued, offered or due
  task automatic drain();
    @(negedge clk);
    while (tick_backlog.size() != 0 || tick_valid || due_levels.size() != 0)
      @(negedge clk);
  endtask

  function automatic void add(input logic op, input logic [1:0] ch, input logic [7:0] lvl);
    queued_tick_t q;
    q.t.opcode   = op;
    q.t.channel  = ch;
    q.t.level_in = lvl;
    q.follow     = 1'b0;
    tick_backlog.push_back(q);
  endfunction

  // Mostly small steps so ramps turn often, with the extremes mixed in
  function automatic logic [6:0] pick_step();
    int r;
    r = $urandom_range(9);
    if (r == 0) return 7'd0;
    if (r == 1) return 7'd127;
    if (r == 2) return 7'd100;
    return 7'($urandom_range(1, 12));
  endfunction

  function automatic logic [6:0] pick_span(input int top);
    int r;
    r = $urandom_range(5);
    if (r == 0) return 7'd0;
    if (r == 1) return 7'(top);
    return 7'($urandom_range(top));
  endfunction

  // Stimulus
  initial begin : stimulus
    queued_tick_t q;
    int           mode;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // disabled after reset: levels pass through
    add(hbr_pkg::OP_PLAIN, hbr_pkg::CH_HUE, 8'd255);
    add(hbr_pkg::OP_HARMONIC, hbr_pkg::CH_VAL, 8'd0);
    add(hbr_pkg::OP_PLAIN, 2'd3, 8'd170);
    drain();

    // zero hue step, high saturation floor, full value step
    set_all(1'b1, 7'd127, 3'd5, 7'd100, 7'd0, 7'd7, 7'd100);
    @(negedge clk);
    add(hbr_pkg::OP_PLAIN, hbr_pkg::CH_HUE, 8'd0);
    add(hbr_pkg::OP_PLAIN, hbr_pkg::CH_HUE, 8'd200);
    add(hbr_pkg::OP_PLAIN, hbr_pkg::CH_SAT, 8'd255);
    add(hbr_pkg::OP_PLAIN, hbr_pkg::CH_SAT, 8'd95);
    add(hbr_pkg::OP_PLAIN, hbr_pkg::CH_SAT, 8'd3);
    add(hbr_pkg::OP_PLAIN, hbr_pkg::CH_VAL, 8'd255);
    add(hbr_pkg::OP_PLAIN, hbr_pkg::CH_VAL, 8'd155);
    add(hbr_pkg::OP_PLAIN, hbr_pkg::CH_VAL, 8'd40);
    add(hbr_pkg::OP_PLAIN, 2'd3, 8'd100);
    add(hbr_pkg::OP_HARMONIC, hbr_pkg::CH_VAL, 8'd0);
    add(hbr_pkg::OP_HARMONIC, hbr_pkg::CH_HUE, 8'd254);
    add(hbr_pkg::OP_HARMONIC, hbr_pkg::CH_SAT, 8'd80);
    drain();

    // zero peaks, low floor, largest steps
    set_all(1'b1, 7'd0, 3'd1, 7'd0, 7'd127, 7'd127, 7'd127);
    @(negedge clk);
    add(hbr_pkg::OP_PLAIN, hbr_pkg::CH_HUE, 8'd255);
    add(hbr_pkg::OP_HARMONIC, hbr_pkg::CH_HUE, 8'd128);
    add(hbr_pkg::OP_PLAIN, hbr_pkg::CH_SAT, 8'd0);
    add(hbr_pkg::OP_PLAIN, hbr_pkg::CH_SAT, 8'd200);
    add(hbr_pkg::OP_HARMONIC, hbr_pkg::CH_VAL, 8'd1);
    add(hbr_pkg::OP_PLAIN, 2'd3, 8'd255);
    drain();

    // random phases: mostly ramps fed back on themselves, some noise
    for (int ph = 0; ph < 8; ph++) begin
      set_all($urandom_range(9) != 0, pick_span(127), 3'($urandom_range(7)),
              pick_span(127), pick_step(), pick_step(), pick_step());
      mode = $urandom_range(2);
      @(negedge clk);
      steady = (ph == 5);
      for (int i = 0; i < 230; i++) begin
        case (mode)
          0: q.t.opcode = ($urandom_range(9) == 0) ?
                          hbr_pkg::OP_HARMONIC : hbr_pkg::OP_PLAIN;
          1: q.t.opcode = ($urandom_range(9) == 0) ?
                          hbr_pkg::OP_PLAIN : hbr_pkg::OP_HARMONIC;
          default: q.t.opcode = $urandom_range(1) ?
                                hbr_pkg::OP_HARMONIC : hbr_pkg::OP_PLAIN;
        endcase
        q.t.channel  = 2'($urandom_range(3));
        q.t.level_in = 8'($urandom_range(255));
        q.follow     = ($urandom_range(3) != 0);
        tick_backlog.push_back(q);
      end
      drain();
      steady = 1'b0;
    end

    repeat (30) @(posedge clk);
    if (mismatches == 0 && due_levels.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
